// File: design/gm_pkg.sv
`timescale 1ns / 1ps
package gm_pkg;

    // default pattern capacity in bytes
    localparam int PAT_MAX_DEF = 64;

    // pattern symbols with special meaning
    localparam logic [7:0] SYM_STAR  = 8'd42;
    localparam logic [7:0] SYM_QMARK = 8'd63;

    // item operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } gm_op_t;

    // command item
    typedef struct packed {
        gm_op_t      opcode;
        logic [7:0]  symbol;
    } gm_cmd_t;

    // result item
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } gm_res_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic clear;
        logic append;
        logic text;
        logic rearm;
    } gm_ctl_t;

endpackage

// File: design/gm_cell.sv
`timescale 1ns / 1ps
module gm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  gm_pkg::gm_ctl_t ctl,
    input  logic [7:0]      symbol,
    input  logic            prev_vld,
    input  logic            carry_in,
    input  logic            match_in,
    output logic            vld,
    output logic            carry_out,
    output logic            match_out,
    output logic            end_hit
);
    import gm_pkg::*;

    logic [7:0] byte_reg;
    logic       vld_reg;
    logic       vld_next;
    logic       raw_reg;
    logic       raw_next;
    logic       closed;
    logic       is_star;
    logic       is_qmark;
    logic       take;

    // decode of the stored pattern byte
    assign is_star  = (byte_reg == SYM_STAR);
    assign is_qmark = (byte_reg == SYM_QMARK);

    // position active after closure over the star run to the left
    assign closed    = raw_reg | carry_in;
    assign carry_out = closed & vld_reg & is_star;
    assign match_out = closed & vld_reg & ~is_star & (is_qmark | (byte_reg == symbol));
    assign end_hit   = closed & ~vld_reg & prev_vld;
    assign vld       = vld_reg;

    // first empty cell takes the appended byte
    assign take = ctl.append & prev_vld & ~vld_reg;

    // valid bit update
    always_comb
    begin
        vld_next = vld_reg;
        if (ctl.clear)
        begin
            vld_next = 1'b0;
        end
        else if (take)
        begin
            vld_next = 1'b1;
        end
    end

    // pre-closure active bit update
    always_comb
    begin
        raw_next = raw_reg;
        if (ctl.rearm)
        begin
            raw_next = 1'b0;
        end
        else if (ctl.text)
        begin
            raw_next = carry_out | match_in;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            raw_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            raw_reg <= raw_next;
        end
    end

    // pattern byte storage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= symbol;
        end
    end

endmodule

// File: design/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// an end-of-text item gives its result on res_item in the cycle after it is accepted
// throughput: one item per cycle of any kind while cmd_stall is low; a row of cells updates all positions at once
// cycle time is set by the star closure, which ripples from cell to cell like a carry chain
// cmd_stall rises only for an end-of-text item while an earlier result waits and is stalled
// reset: pattern empty, overflow cleared, only position zero active, no result pending
module wildcard_glob_matcher #(
    parameter int PAT_MAX = gm_pkg::PAT_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  gm_pkg::gm_cmd_t cmd_item,
    output logic            res_valid,
    input  logic            res_stall,
    output gm_pkg::gm_res_t res_item
);
    import gm_pkg::*;

    logic              cmd_fire;
    gm_ctl_t           ctl;
    logic [PAT_MAX:0]  pv;
    logic [PAT_MAX:0]  carry;
    logic [PAT_MAX:0]  match;
    logic [PAT_MAX:0]  hit;
    logic              hit_any;

    logic    start_reg;
    logic    start_next;
    logic    end_raw_reg;
    logic    end_raw_next;
    logic    overflow_reg;
    logic    overflow_next;
    logic    res_valid_reg;
    logic    res_valid_next;
    gm_res_t res_item_reg;
    logic    res_load;

    // input handshake
    assign cmd_stall = res_valid_reg & res_stall & (cmd_item.opcode == OP_END);
    assign cmd_fire  = cmd_valid & ~cmd_stall;

    // broadcast control
    always_comb
    begin
        ctl.clear  = cmd_fire & (cmd_item.opcode == OP_CLEAR);
        ctl.append = cmd_fire & (cmd_item.opcode == OP_APPEND);
        ctl.text   = cmd_fire & (cmd_item.opcode == OP_TEXT);
        ctl.rearm  = cmd_fire & (cmd_item.opcode != OP_TEXT);
    end

    // chain heads
    assign pv[0]    = 1'b1;
    assign carry[0] = start_reg;
    assign match[0] = 1'b0;

    // row of pattern position cells
    genvar gi;
    generate
        for (gi = 0; gi < PAT_MAX; gi++)
        begin : g_cell
            gm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .symbol    (cmd_item.symbol),
                .prev_vld  (pv[gi]),
                .carry_in  (carry[gi]),
                .match_in  (match[gi]),
                .vld       (pv[gi+1]),
                .carry_out (carry[gi+1]),
                .match_out (match[gi+1]),
                .end_hit   (hit[gi])
            );
        end
    endgenerate

    // position past the last cell is the end only when the pattern is full
    assign hit[PAT_MAX] = (end_raw_reg | carry[PAT_MAX]) & pv[PAT_MAX];
    assign hit_any      = |hit;

    // position zero seed, end position bit and overflow flag
    always_comb
    begin
        start_next    = start_reg;
        end_raw_next  = end_raw_reg;
        overflow_next = overflow_reg;
        if (ctl.rearm)
        begin
            start_next   = 1'b1;
            end_raw_next = 1'b0;
        end
        else if (ctl.text)
        begin
            start_next   = 1'b0;
            end_raw_next = match[PAT_MAX];
        end
        if (ctl.clear)
        begin
            overflow_next = 1'b0;
        end
        else if (ctl.append & pv[PAT_MAX])
        begin
            overflow_next = 1'b1;
        end
    end

    // result stage
    assign res_load       = cmd_fire & (cmd_item.opcode == OP_END);
    assign res_valid_next = res_load | (res_valid_reg & res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b1;
            end_raw_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            end_raw_reg   <= end_raw_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_item_reg.matched          <= hit_any & ~overflow_reg;
            res_item_reg.pattern_overflow <= overflow_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // cells fill from position zero without gaps
    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((pv >> 1) & ~pv) == '0)
        else $error("pattern cells filled out of order");

    // the pattern end sits at no more than one position
    a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("more than one end position hit");

    // an accepted end of text always produces a result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> res_valid)
        else $error("end of text gave no result");

    // clear empties the pattern and drops the overflow flag
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (!overflow_reg && !pv[1]))
        else $error("clear left pattern state behind");

    // input back-pressure only while a result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid)
        else $error("stall without a pending result");

endmodule
